// File: rtl/infix_to_postfix_converter_top_assert.svh
// assertion macros used by the converter rtl
`ifndef INFIX_TO_POSTFIX_CONVERTER_TOP_ASSERT_SVH
`define INFIX_TO_POSTFIX_CONVERTER_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
// checked outside reset
`define ITP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked on every edge, reset included
`define ITP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ITP_ASSERT(lbl, clk, rst_n, prop, msg)
`define ITP_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// File: rtl/itp_pkg.sv
// types, character codes, rank function and operand test of the infix to postfix converter
package itp_pkg;

    typedef logic [7:0] t_char;
    typedef logic signed [2:0] t_rank;

    localparam t_char C_CARET = 8'h5E;
    localparam t_char C_STAR  = 8'h2A;
    localparam t_char C_SLASH = 8'h2F;
    localparam t_char C_PLUS  = 8'h2B;
    localparam t_char C_MINUS = 8'h2D;
    localparam t_char C_LPAR  = 8'h28;
    localparam t_char C_RPAR  = 8'h29;
    localparam t_char C_LO_A  = 8'h61;
    localparam t_char C_LO_Z  = 8'h7A;
    localparam t_char C_UP_A  = 8'h41;
    localparam t_char C_UP_Z  = 8'h5A;
    localparam t_char C_DIG_0 = 8'h30;
    localparam t_char C_DIG_9 = 8'h39;

    localparam t_rank RANK_POW  = 3'sd3;
    localparam t_rank RANK_MUL  = 3'sd2;
    localparam t_rank RANK_ADD  = 3'sd1;
    localparam t_rank RANK_NONE = -3'sd1;

    function automatic t_rank f_rank(input t_char c);
        t_rank r;
        priority if (c == C_CARET) begin
            r = RANK_POW;
        end else if (c == C_STAR || c == C_SLASH) begin
            r = RANK_MUL;
        end else if (c == C_PLUS || c == C_MINUS) begin
            r = RANK_ADD;
        end else begin
            r = RANK_NONE;
        end
        return r;
    endfunction

    function automatic logic f_is_operand(input t_char c);
        return (c >= C_LO_A && c <= C_LO_Z) || (c >= C_UP_A && c <= C_UP_Z) ||
               (c >= C_DIG_0 && c <= C_DIG_9);
    endfunction

endpackage

// File: rtl/itp_in_if.sv
// input channel: one infix byte and its end flag
interface itp_in_if;
    logic          valid;
    logic          ready;
    itp_pkg::t_char in_char;
    logic          end_of_expr;

    modport source (output valid, output in_char, output end_of_expr, input ready);
    modport sink   (input valid, input in_char, input end_of_expr, output ready);
endinterface

// File: rtl/itp_out_if.sv
// output channel: one postfix byte with its flags
interface itp_out_if;
    logic          valid;
    logic          ready;
    itp_pkg::t_char out_char;
    logic          run_last;
    logic          overflow_seen;

    modport source (output valid, output out_char, output run_last, output overflow_seen,
                    input ready);
    modport sink   (input valid, input out_char, input run_last, input overflow_seen,
                    output ready);
endinterface

// File: rtl/itp_ram.sv
// generic single write port ram with registered read
module itp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/infix_to_postfix_converter_top.sv
// Shunting-yard infix to postfix converter.
// i_in takes one expression byte per transfer with an end flag; o_out gives postfix bytes,
// each with run_last on the final result caused by that byte and the sticky overflow flag.
// The operator stack sits in a ram with registered read; its address always
// follows the next stack count, so the top entry is ready each cycle and a write to the
// entry being read is forwarded.
// Each byte is accepted, evaluated and released; evaluation may pop entries to the output,
// and an end byte then flushes every remaining entry and clears the overflow flag.
// Pops run at one per cycle while the output can take them, limited by the single ram
// read port. A byte is accepted only after the previous one is done. The last result
// of a byte without pops reaches o_out through the hold and then the output register.
// The last result of a byte is held back until the block knows no more follow; the
// output register frees the converter from the receiver except when that register is
// still full, in which case the converter waits for as long as the receiver stalls.
// Reset clears the stack count, the overflow flag and all handshake state; ram contents
// are not cleared and never read before being written.
// A push onto a full stack is dropped and sets the overflow flag until the end byte.
module infix_to_postfix_converter_top #(
    parameter int STACK_DEPTH = 16
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    itp_in_if.sink   i_in,
    itp_out_if.source o_out
);
    `include "infix_to_postfix_converter_top_assert.svh"

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_PRE   = 4'b0010,
        S_FLUSH = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state          r_state, n_state;
    itp_pkg::t_char  r_char;
    logic            r_end;
    logic [CW-1:0]   r_count, n_count;
    logic            r_ovf, n_ovf;
    logic            r_hold_v, n_hold_v;
    itp_pkg::t_char  r_hold_c, n_hold_c;
    logic            r_hold_o, n_hold_o;
    logic            r_out_v, n_out_v;
    itp_pkg::t_char  r_out_c, n_out_c;
    logic            r_out_l, n_out_l;
    logic            r_out_o, n_out_o;
    logic            r_fwd_v;
    itp_pkg::t_char  r_fwd_c;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr, ram_raddr;
    itp_pkg::t_char  ram_rdata;
    logic [CW-1:0]   rd_idx;
    itp_pkg::t_char  top_c;
    logic            have, full, out_free, emit_ok, accept;
    logic            do_emit, do_pop, do_push, do_final;
    itp_pkg::t_char  emit_c;
    t_state          after_pre;

    assign accept    = i_in.valid && i_in.ready;
    assign top_c     = r_fwd_v ? r_fwd_c : ram_rdata;
    assign have      = r_count != '0;
    assign full      = r_count == CW'(STACK_DEPTH);
    assign out_free  = !r_out_v || o_out.ready;
    assign emit_ok   = !r_hold_v || out_free;
    assign after_pre = r_end ? S_FLUSH : S_DONE;

    always_comb begin
        n_state  = r_state;
        do_emit  = 1'b0;
        do_pop   = 1'b0;
        do_push  = 1'b0;
        do_final = 1'b0;
        emit_c   = top_c;
        n_ovf    = r_ovf;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_PRE;
                end
            end
            S_PRE: begin
                priority if (itp_pkg::f_is_operand(r_char)) begin
                    if (emit_ok) begin
                        do_emit = 1'b1;
                        emit_c  = r_char;
                        n_state = after_pre;
                    end
                end else if (r_char == itp_pkg::C_LPAR) begin
                    do_push = 1'b1;
                    n_state = after_pre;
                end else if (r_char == itp_pkg::C_RPAR) begin
                    if (have && top_c != itp_pkg::C_LPAR) begin
                        if (emit_ok) begin
                            do_emit = 1'b1;
                            do_pop  = 1'b1;
                        end
                    end else begin
                        // drop the matching open, or ignore a close on an empty stack
                        do_pop  = have;
                        n_state = after_pre;
                    end
                end else begin
                    if (have && itp_pkg::f_rank(r_char) <= itp_pkg::f_rank(top_c)) begin
                        if (emit_ok) begin
                            do_emit = 1'b1;
                            do_pop  = 1'b1;
                        end
                    end else begin
                        do_push = 1'b1;
                        n_state = after_pre;
                    end
                end
            end
            S_FLUSH: begin
                if (have) begin
                    if (emit_ok) begin
                        do_emit = 1'b1;
                        do_pop  = 1'b1;
                    end
                end else begin
                    n_ovf   = 1'b0;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_hold_v) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    do_final = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (do_push && full) begin
            n_ovf = 1'b1;
        end
    end

    // stack count and ram write
    always_comb begin
        n_count = r_count;
        ram_we  = 1'b0;
        if (do_pop) begin
            n_count = r_count - CW'(1);
        end else if (do_push && !full) begin
            ram_we  = 1'b1;
            n_count = r_count + CW'(1);
        end
    end

    assign ram_waddr = r_count[AW-1:0];
    assign rd_idx    = n_count - CW'(1);
    assign ram_raddr = (n_count == '0) ? '0 : rd_idx[AW-1:0];

    // hold stage keeps the newest result until the next one shows whether it is last
    always_comb begin
        n_hold_v = r_hold_v;
        n_hold_c = r_hold_c;
        n_hold_o = r_hold_o;
        n_out_v  = r_out_v;
        n_out_c  = r_out_c;
        n_out_l  = r_out_l;
        n_out_o  = r_out_o;
        if (r_out_v && o_out.ready) begin
            n_out_v = 1'b0;
        end
        if ((do_emit && r_hold_v) || do_final) begin
            n_out_v = 1'b1;
            n_out_c = r_hold_c;
            n_out_l = do_final;
            n_out_o = r_hold_o;
        end
        if (do_emit) begin
            n_hold_v = 1'b1;
            n_hold_c = emit_c;
            n_hold_o = r_ovf;
        end else if (do_final) begin
            n_hold_v = 1'b0;
        end
    end

    itp_ram #(
        .WIDTH (8),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_char),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovf    <= 1'b0;
            r_hold_v <= 1'b0;
            r_out_v  <= 1'b0;
            r_fwd_v  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovf    <= n_ovf;
            r_hold_v <= n_hold_v;
            r_out_v  <= n_out_v;
            r_fwd_v  <= ram_we && (ram_waddr == ram_raddr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_char <= i_in.in_char;
            r_end  <= i_in.end_of_expr;
        end
        r_hold_c <= n_hold_c;
        r_hold_o <= n_hold_o;
        r_out_c  <= n_out_c;
        r_out_l  <= n_out_l;
        r_out_o  <= n_out_o;
        r_fwd_c  <= r_char;
    end

    assign i_in.ready          = r_state == S_IDLE;
    assign o_out.valid         = r_out_v;
    assign o_out.out_char      = r_out_c;
    assign o_out.run_last      = r_out_l;
    assign o_out.overflow_seen = r_out_o;

    `ITP_ASSERT_ALWAYS(a_count_bound, i_clk, !i_rst_n || r_count <= CW'(STACK_DEPTH), "stack count above depth")
    `ITP_ASSERT(a_accept_to_pre, i_clk, i_rst_n, accept |=> r_state == S_PRE, "accept did not start evaluation")
    `ITP_ASSERT(a_final_last, i_clk, i_rst_n, do_final |=> (r_out_v && r_out_l), "final result not marked last")
    `ITP_ASSERT(a_flush_clears, i_clk, i_rst_n, (r_state == S_FLUSH && !have) |=> (!r_ovf && r_count == '0), "flush left state behind")
    `ITP_ASSERT(a_idle_no_hold, i_clk, i_rst_n, r_state == S_IDLE |-> !r_hold_v, "held result left in idle")
endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// testbench of the infix to postfix converter: stack scoreboard and randomly paced handshakes

class postfix_scoreboard;
    typedef struct {
        itp_pkg::t_char ch;
        bit             last;
        bit             ovf;
    } t_postfix_byte;

    int unsigned    depth_max;
    itp_pkg::t_char op_mem[];
    int unsigned    op_count;
    bit             ovf_sticky;
    t_postfix_byte  postfix_q[$];
    t_postfix_byte  held;
    bit             held_valid;
    int unsigned    errors;

    function new(int unsigned depth);
        depth_max  = depth;
        op_mem     = new[depth];
        op_count   = 0;
        ovf_sticky = 1'b0;
        held_valid = 1'b0;
        errors     = 0;
    endfunction

    static function int op_rank(itp_pkg::t_char c);
        case (c)
            itp_pkg::C_CARET:                  return itp_pkg::RANK_POW;
            itp_pkg::C_STAR, itp_pkg::C_SLASH: return itp_pkg::RANK_MUL;
            itp_pkg::C_PLUS, itp_pkg::C_MINUS: return itp_pkg::RANK_ADD;
            default:                           return itp_pkg::RANK_NONE;
        endcase
    endfunction

    static function bit is_operand(itp_pkg::t_char c);
        return (c >= itp_pkg::C_LO_A && c <= itp_pkg::C_LO_Z) ||
               (c >= itp_pkg::C_UP_A && c <= itp_pkg::C_UP_Z) ||
               (c >= itp_pkg::C_DIG_0 && c <= itp_pkg::C_DIG_9);
    endfunction

    // the newest byte is held back so the last one of a transfer can be marked
    function void emit(itp_pkg::t_char c);
        if (held_valid) postfix_q.push_back(held);
        held.ch    = c;
        held.last  = 1'b0;
        held.ovf   = ovf_sticky;
        held_valid = 1'b1;
    endfunction

    function void pop_to_output();
        emit(op_mem[op_count - 1]);
        op_count--;
    endfunction

    function void push_op(itp_pkg::t_char c);
        if (op_count >= depth_max) begin
            ovf_sticky = 1'b1;
        end else begin
            op_mem[op_count] = c;
            op_count++;
        end
    endfunction

    function void note_byte(itp_pkg::t_char c, bit eoe);
        int r;
        if (is_operand(c)) begin
            emit(c);
        end else if (c == itp_pkg::C_LPAR) begin
            push_op(c);
        end else if (c == itp_pkg::C_RPAR) begin
            while (op_count > 0 && op_mem[op_count - 1] != itp_pkg::C_LPAR) pop_to_output();
            if (op_count > 0) op_count--;
        end else begin
            r = op_rank(c);
            while (op_count > 0 && r <= op_rank(op_mem[op_count - 1])) pop_to_output();
            push_op(c);
        end
        if (eoe) begin
            while (op_count > 0) pop_to_output();
            ovf_sticky = 1'b0;
        end
        if (held_valid) begin
            held.last = 1'b1;
            postfix_q.push_back(held);
            held_valid = 1'b0;
        end
    endfunction

    function void check_result(itp_pkg::t_char ch, logic last, logic ovf);
        t_postfix_byte want;
        if (postfix_q.size() == 0) begin
            $display("%0t: unexpected result out_char %h run_last %b overflow_seen %b",
                     $time, ch, last, ovf);
            errors++;
            return;
        end
        want = postfix_q.pop_front();
        if (ch !== want.ch) begin
            $display("%0t: out_char expected %h actual %h", $time, want.ch, ch);
            errors++;
        end
        if (last !== want.last) begin
            $display("%0t: run_last expected %b actual %b", $time, want.last, last);
            errors++;
        end
        if (ovf !== want.ovf) begin
            $display("%0t: overflow_seen expected %b actual %b", $time, want.ovf, ovf);
            errors++;
        end
    endfunction

    function int unsigned pending();
        return postfix_q.size();
    endfunction
endclass

module testbench;
    localparam int DEPTH        = 16;
    localparam int RANDOM_ITEMS = 280;

    typedef struct {
        itp_pkg::t_char ch;
        bit             eoe;
    } t_infix_item;

    logic i_clk;
    logic i_rst_n;

    itp_in_if  in_ch();
    itp_out_if out_ch();

    infix_to_postfix_converter_top #(.STACK_DEPTH(DEPTH)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    postfix_scoreboard sb = new(DEPTH);
    t_infix_item       item_q[$];
    bit                tx_calm;
    int                tx_calm_left;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #8_000_000;
        $display("testbench NOT OK");
        $finish;
    end

    function automatic void add_byte(itp_pkg::t_char c, bit eoe);
        t_infix_item it;
        it.ch  = c;
        it.eoe = eoe;
        item_q.push_back(it);
    endfunction

    // end flag goes on the final byte of the sequence
    function automatic void add_seq(itp_pkg::t_char seq[$]);
        foreach (seq[k]) add_byte(seq[k], k == seq.size() - 1);
    endfunction

    function automatic itp_pkg::t_char rand_operand();
        case ($urandom_range(0, 2))
            0:       return itp_pkg::C_LO_A + itp_pkg::t_char'($urandom_range(0, 25));
            1:       return itp_pkg::C_UP_A + itp_pkg::t_char'($urandom_range(0, 25));
            default: return itp_pkg::C_DIG_0 + itp_pkg::t_char'($urandom_range(0, 9));
        endcase
    endfunction

    function automatic itp_pkg::t_char rand_operator();
        itp_pkg::t_char c;
        case ($urandom_range(0, 17))
            0, 1, 2:    c = itp_pkg::C_CARET;
            3, 4, 5:    c = itp_pkg::C_STAR;
            6, 7, 8:    c = itp_pkg::C_SLASH;
            9, 10, 11:  c = itp_pkg::C_PLUS;
            12, 13, 14: c = itp_pkg::C_MINUS;
            default: begin
                // some byte that ranks as an unknown operator
                do c = itp_pkg::t_char'($urandom_range(0, 255));
                while (itp_pkg::f_is_operand(c) || c == itp_pkg::C_LPAR ||
                       c == itp_pkg::C_RPAR || itp_pkg::f_rank(c) != itp_pkg::RANK_NONE);
            end
        endcase
        return c;
    endfunction

    function automatic void queue_expr();
        itp_pkg::t_char seq[$];
        int    terms;
        int    opens;
        terms = $urandom_range(1, 6);
        opens = 0;
        for (int k = 0; k < terms; k++) begin
            if (k > 0) seq.push_back(rand_operator());
            while (opens < 6 && $urandom_range(0, 3) == 0) begin
                seq.push_back(itp_pkg::C_LPAR);
                opens++;
            end
            seq.push_back(rand_operand());
            while (opens > 0 && $urandom_range(0, 2) == 0) begin
                seq.push_back(itp_pkg::C_RPAR);
                opens--;
            end
        end
        // now and then leave opens unmatched for the flush
        if ($urandom_range(0, 6) != 0) begin
            while (opens > 0) begin
                seq.push_back(itp_pkg::C_RPAR);
                opens--;
            end
        end
        add_seq(seq);
    endfunction

    function automatic void queue_deep();
        itp_pkg::t_char seq[$];
        int    opens;
        opens = $urandom_range(13, 20);
        repeat (opens) seq.push_back(itp_pkg::C_LPAR);
        seq.push_back(rand_operand());
        seq.push_back(itp_pkg::C_PLUS);
        seq.push_back(itp_pkg::C_LPAR);
        seq.push_back(rand_operand());
        seq.push_back(itp_pkg::C_STAR);
        seq.push_back(rand_operand());
        seq.push_back(itp_pkg::C_CARET);
        seq.push_back(rand_operand());
        repeat ($urandom_range(0, opens)) seq.push_back(itp_pkg::C_RPAR);
        add_seq(seq);
    endfunction

    function automatic void queue_noise();
        int n;
        n = $urandom_range(1, 8);
        for (int k = 0; k < n; k++) begin
            add_byte(itp_pkg::t_char'($urandom_range(0, 255)),
                     (k == n - 1) ? ($urandom_range(0, 1) == 1) : ($urandom_range(0, 5) == 0));
        end
    endfunction

    function automatic int tx_gap();
        int pct;
        if (tx_calm_left == 0) begin
            tx_calm      = ($urandom_range(0, 3) == 0);
            tx_calm_left = $urandom_range(20, 80);
        end else begin
            tx_calm_left--;
        end
        if (tx_calm) return 0;
        pct = $urandom_range(0, 99);
        if (pct < 55) return 0;
        if (pct < 90) return $urandom_range(1, 3);
        if (pct < 97) return $urandom_range(4, 8);
        return $urandom_range(12, 40);
    endfunction

    task automatic send_item(t_infix_item it, int gap);
        if (gap > 0) begin
            @(negedge i_clk);
            in_ch.valid       <= 1'b0;
            in_ch.in_char     <= itp_pkg::t_char'($urandom_range(0, 255));
            in_ch.end_of_expr <= 1'($urandom_range(0, 1));
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_ch.valid       <= 1'b1;
        in_ch.in_char     <= it.ch;
        in_ch.end_of_expr <= it.eoe;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        sb.note_byte(it.ch, it.eoe);
    endtask

    // receiver side: mostly ready, short and long stalls, calm stretches
    initial begin : rx_pacing
        int stall_left;
        int calm_left;
        int pct;
        bit calm;
        stall_left    = 0;
        calm_left     = 0;
        calm          = 1'b0;
        out_ch.ready  = 1'b0;
        forever begin
            @(negedge i_clk);
            if (calm_left == 0) begin
                calm      = ($urandom_range(0, 3) == 0);
                calm_left = $urandom_range(50, 300);
            end else begin
                calm_left--;
            end
            if (stall_left > 0) begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                pct = $urandom_range(0, 99);
                if (!calm && pct < 15) begin
                    out_ch.ready <= 1'b0;
                    stall_left = $urandom_range(0, 2);
                end else if (!calm && pct < 17) begin
                    out_ch.ready <= 1'b0;
                    stall_left = $urandom_range(9, 39);
                end else begin
                    out_ch.ready <= 1'b1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
            sb.check_result(out_ch.out_char, out_ch.run_last, out_ch.overflow_seen);
    end

    initial begin : stimulus
        int pct;
        i_rst_n           = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.in_char     = '0;
        in_ch.end_of_expr = 1'b0;
        tx_calm           = 1'b0;
        tx_calm_left      = 0;

        // close on an empty stack, every operator, operand extremes
        add_byte(itp_pkg::C_RPAR, 1'b0);
        add_byte(itp_pkg::C_UP_A, 1'b0);
        add_byte(itp_pkg::C_STAR, 1'b0);
        add_byte(itp_pkg::C_DIG_9, 1'b0);
        add_byte(itp_pkg::C_CARET, 1'b0);
        add_byte(itp_pkg::C_LO_Z, 1'b0);
        add_byte(itp_pkg::C_MINUS, 1'b0);
        add_byte(itp_pkg::C_DIG_0, 1'b0);
        add_byte(itp_pkg::C_SLASH, 1'b0);
        add_byte(itp_pkg::C_LO_A, 1'b0);
        add_byte(itp_pkg::C_PLUS, 1'b0);
        add_byte(itp_pkg::C_UP_Z, 1'b1);
        // unknown operator pops an open, close without open, open left at the end
        add_byte(itp_pkg::C_LPAR, 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(itp_pkg::C_RPAR, 1'b0);
        add_byte(itp_pkg::C_LPAR, 1'b1);
        // fill the stack, drop one push, then flush with the sticky flag set
        repeat (DEPTH + 1) add_byte(itp_pkg::C_LPAR, 1'b0);
        add_byte(itp_pkg::C_DIG_0 + 8'd7, 1'b1);

        while (item_q.size() < RANDOM_ITEMS + 35) begin
            pct = $urandom_range(0, 99);
            if (pct < 70) queue_expr();
            else if (pct < 82) queue_deep();
            else queue_noise();
        end

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (item_q[k]) send_item(item_q[k], tx_gap());
        @(negedge i_clk);
        in_ch.valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end
endmodule

// File: sim.f
+incdir+rtl
rtl/itp_pkg.sv
rtl/itp_in_if.sv
rtl/itp_out_if.sv
rtl/itp_ram.sv
rtl/infix_to_postfix_converter_top.sv
bench/testbench.sv
